### rtl/sm4_pkg.sv
package sm4_pkg;

    // Round count of the cipher and of the key schedule
    localparam int ROUNDS = 32;

    typedef logic [31:0] t_word;

    // Four working words, x0 is the oldest
    typedef struct packed {
        t_word x0;
        t_word x1;
        t_word x2;
        t_word x3;
    } t_block;

    // What moves from one round stage to the next
    typedef struct packed {
        logic   valid;
        t_block data;
    } t_stage;

    // System parameter FK
    localparam t_word FK0 = 32'ha3b1bac6;
    localparam t_word FK1 = 32'h56aa3350;
    localparam t_word FK2 = 32'h677d9197;
    localparam t_word FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    function automatic t_word rotl(t_word v, int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Byte-wise S-box substitution
    function automatic t_word tau(t_word v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // Linear transform of the data rounds
    function automatic t_word l_data(t_word v);
        return v ^ rotl(v, 2) ^ rotl(v, 10) ^ rotl(v, 18) ^ rotl(v, 24);
    endfunction

    // Linear transform of the key schedule
    function automatic t_word l_key(t_word v);
        return v ^ rotl(v, 13) ^ rotl(v, 23);
    endfunction

    // CK word: byte j is (4*idx + j) * 7 mod 256, first byte on top
    function automatic t_word ck_word(logic [7:0] idx);
        t_word      w;
        logic [7:0] b;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            b = 8'((idx << 2) + 8'(j));
            w = {w[23:0], 8'(b * 8'd7)};
        end
        return w;
    endfunction

endpackage

### rtl/sm4_key_exp.sv
module sm4_key_exp #(
    parameter int ROUNDS = sm4_pkg::ROUNDS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [127:0]   i_key,
    output logic           o_busy,
    output sm4_pkg::t_word o_round_keys [ROUNDS]
);

    localparam int CNT_W = $clog2(ROUNDS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUNDS - 1);

    logic           r_busy;
    logic [CNT_W-1:0] r_cnt;
    sm4_pkg::t_word r_w [4];
    sm4_pkg::t_word r_rk [ROUNDS];
    sm4_pkg::t_word n_key;

    // One schedule round per cycle
    assign n_key = r_w[0] ^ sm4_pkg::l_key(sm4_pkg::tau(
                   r_w[1] ^ r_w[2] ^ r_w[3] ^ sm4_pkg::ck_word(8'(r_cnt))));

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Working words and round key file
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w[0] <= i_key[127:96] ^ sm4_pkg::FK0;
            r_w[1] <= i_key[95:64]  ^ sm4_pkg::FK1;
            r_w[2] <= i_key[63:32]  ^ sm4_pkg::FK2;
            r_w[3] <= i_key[31:0]   ^ sm4_pkg::FK3;
        end else if (r_busy) begin
            r_w[0]       <= r_w[1];
            r_w[1]       <= r_w[2];
            r_w[2]       <= r_w[3];
            r_w[3]       <= n_key;
            r_rk[r_cnt]  <= n_key;
        end
    end

    assign o_busy       = r_busy;
    assign o_round_keys = r_rk;

endmodule

### rtl/sm4_round.sv
module sm4_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sm4_pkg::t_stage i_stage,
    input  sm4_pkg::t_word  i_rk,
    input  logic            i_ready_next,
    output logic            o_ready,
    output sm4_pkg::t_stage o_stage
);

    logic            r_valid;
    sm4_pkg::t_block r_data;
    sm4_pkg::t_word  n_x;

    // Stage takes a new item when empty or when its item moves on
    assign o_ready = !r_valid || i_ready_next;

    assign n_x = i_stage.data.x0 ^ sm4_pkg::l_data(sm4_pkg::tau(
                 i_stage.data.x1 ^ i_stage.data.x2 ^ i_stage.data.x3 ^ i_rk));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_stage.valid;
        end
    end

    // Word rotation plus the new word
    always_ff @(posedge i_clk) begin
        if (o_ready && i_stage.valid) begin
            r_data.x0 <= i_stage.data.x1;
            r_data.x1 <= i_stage.data.x2;
            r_data.x2 <= i_stage.data.x3;
            r_data.x3 <= n_x;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.data  = r_data;

endmodule

### rtl/sm4_block_cipher.sv
// SM4 block cipher, 128-bit block and key, fully pipelined with one round per
// register stage: a block enters on every cycle in which s_axis_tready is high,
// so sustained throughput is one block per clock while neither the output side
// nor the key schedule stalls; latency is set by the round pipeline. Blocks
// travel as two 64-bit big-endian halves in tdata and stalls on the output side
// back up stage by stage without loss. Writing key_high or key_low starts the
// key schedule, which computes one round key per cycle; s_axis_tready stays low
// while it runs. Load both key halves before sending data. decrypt_mode selects
// the reversed round key order. Registers sit at byte addresses 0, 8 and 16.
module sm4_block_cipher #(
    parameter int ROUNDS = sm4_pkg::ROUNDS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] block_high, [127:64] block_low
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // [63:0] result_high, [127:64] result_low
);

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_DECRYPT  = 2'd2;

    logic [63:0]     r_key_high;
    logic [63:0]     r_key_low;
    logic            r_decrypt;
    logic            w_write;
    logic [1:0]      w_index;
    logic            w_key_start;
    logic [127:0]    w_key;
    logic            w_busy;
    sm4_pkg::t_word  w_rk [ROUNDS];
    sm4_pkg::t_stage w_stage [ROUNDS+1];
    logic            w_ready [ROUNDS+1];

    // Register writes
    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_decrypt  <= 1'b0;
        end else if (w_write) begin
            unique case (w_index)
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LOW:  r_key_low  <= pwdata;
                REG_DECRYPT:  r_decrypt  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (w_index)
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LOW:  prdata = r_key_low;
            REG_DECRYPT:  prdata = {63'd0, r_decrypt};
            default:      prdata = '0;
        endcase
    end

    // Key schedule sees the key as it stands after this write
    assign w_key_start = w_write && (w_index == REG_KEY_HIGH || w_index == REG_KEY_LOW);
    assign w_key = {(w_index == REG_KEY_HIGH) ? pwdata : r_key_high,
                    (w_index == REG_KEY_LOW)  ? pwdata : r_key_low};

    sm4_key_exp #(
        .ROUNDS(ROUNDS)
    ) u_key_exp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_key_start),
        .i_key       (w_key),
        .o_busy      (w_busy),
        .o_round_keys(w_rk)
    );

    // Pipeline entry
    assign w_stage[0].valid   = s_axis_tvalid && !w_busy;
    assign w_stage[0].data.x0 = s_axis_tdata[63:32];
    assign w_stage[0].data.x1 = s_axis_tdata[31:0];
    assign w_stage[0].data.x2 = s_axis_tdata[127:96];
    assign w_stage[0].data.x3 = s_axis_tdata[95:64];
    assign s_axis_tready      = w_ready[0] && !w_busy;

    // One round per stage
    for (genvar k = 0; k < ROUNDS; k++) begin : g_round
        sm4_round u_round (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_stage     (w_stage[k]),
            .i_rk        (r_decrypt ? w_rk[ROUNDS-1-k] : w_rk[k]),
            .i_ready_next(w_ready[k+1]),
            .o_ready     (w_ready[k]),
            .o_stage     (w_stage[k+1])
        );
    end

    // Last stage register is the output register, words reversed
    assign w_ready[ROUNDS]      = m_axis_tready;
    assign m_axis_tvalid        = w_stage[ROUNDS].valid;
    assign m_axis_tdata[63:32]  = w_stage[ROUNDS].data.x3;
    assign m_axis_tdata[31:0]   = w_stage[ROUNDS].data.x2;
    assign m_axis_tdata[127:96] = w_stage[ROUNDS].data.x1;
    assign m_axis_tdata[95:64]  = w_stage[ROUNDS].data.x0;

endmodule

### bench/sm4_stream_checker.sv
`timescale 1ns / 100ps

// Watches the register port and both streams, runs its own SM4 model on every
// accepted block and compares each output transfer with the oldest prediction.
module sm4_stream_checker #(
    parameter logic [4:0] KEY_HIGH_ADDR = 5'd0,
    parameter logic [4:0] KEY_LOW_ADDR  = 5'd8,
    parameter logic [4:0] DECRYPT_ADDR  = 5'd16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // register port
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [4:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    // block input stream
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [127:0] i_in_data,    // [63:0] block_high, [127:64] block_low
    // block output stream
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [127:0] i_out_data,   // [63:0] result_high, [127:64] result_low
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [63:0] res_high;
        logic [63:0] res_low;
    } t_cipher_out;

    // S-box, byte 0 in the top bits
    localparam logic [2047:0] SBOX_BITS = {
        128'hd690e9fecce13db716b614c228fb2c05,
        128'h2b679a762abe04c3aa44132649860699,
        128'h9c4250f491ef987a33540b43edcfac62,
        128'he4b31ca9c908e89580df94fa758f3fa6,
        128'h4707a7fcf37317ba83593c19e6854fa8,
        128'h686b81b27164da8bf8eb0f4b70569d35,
        128'h1e240e5e6358d1a225227c3b01217887,
        128'hd40046579fd327524c3602e7a0c4c89e,
        128'heabf8ad240c738b5a3f7f2cef96115a1,
        128'he0ae5da49b341a55ad933230f58cb1e3,
        128'h1df6e22e8266ca60c02923ab0d534e6f,
        128'hd5db3745defd8e2f03ff6a726d6c5b51,
        128'h8d1baf92bbddbc7f11d95c411f105ad8,
        128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
        128'h8969974a0c96777e65b9f109c56ec684,
        128'h18f07dec3adc4d2079ee5f3ed7cb3948
    };

    localparam logic [127:0] FK_WORDS = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

    // shadow of the cipher's registers and key schedule
    logic [63:0]     key_hi;
    logic [63:0]     key_lo;
    logic            dec_mode;
    sm4_pkg::t_word  sched_keys [sm4_pkg::ROUNDS];
    t_cipher_out     cipher_results_q [$];
    int              failures;

    function automatic sm4_pkg::t_word rot_left(sm4_pkg::t_word v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic sm4_pkg::t_word sbox_word(sm4_pkg::t_word v);
        sm4_pkg::t_word r;
        for (int b = 0; b < 4; b++) begin
            r[8*b +: 8] = SBOX_BITS[2047 - 8 * int'(v[8*b +: 8]) -: 8];
        end
        return r;
    endfunction

    // CK word i: byte j is (4i + j) * 7 mod 256, first byte on top
    function automatic sm4_pkg::t_word ck_const(int unsigned i);
        sm4_pkg::t_word w;
        int unsigned    ck_byte;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            ck_byte = (4 * i + j) * 7;
            w = {w[23:0], ck_byte[7:0]};
        end
        return w;
    endfunction

    // key schedule from both key halves as they stand now
    function automatic void load_round_keys();
        sm4_pkg::t_word w [4];
        sm4_pkg::t_word nk;
        w[0] = key_hi[63:32] ^ FK_WORDS[127:96];
        w[1] = key_hi[31:0]  ^ FK_WORDS[95:64];
        w[2] = key_lo[63:32] ^ FK_WORDS[63:32];
        w[3] = key_lo[31:0]  ^ FK_WORDS[31:0];
        for (int i = 0; i < sm4_pkg::ROUNDS; i++) begin
            nk = sbox_word(w[1] ^ w[2] ^ w[3] ^ ck_const(i));
            nk = w[0] ^ nk ^ rot_left(nk, 13) ^ rot_left(nk, 23);
            w[0] = w[1];
            w[1] = w[2];
            w[2] = w[3];
            w[3] = nk;
            sched_keys[i] = nk;
        end
    endfunction

    // 32 data rounds, round keys reversed for decryption, words out reversed
    function automatic t_cipher_out sm4_crypt_block(logic [63:0] blk_hi, logic [63:0] blk_lo);
        sm4_pkg::t_word x [4];
        sm4_pkg::t_word rk;
        sm4_pkg::t_word t;
        t_cipher_out    res;
        x[0] = blk_hi[63:32];
        x[1] = blk_hi[31:0];
        x[2] = blk_lo[63:32];
        x[3] = blk_lo[31:0];
        for (int r = 0; r < sm4_pkg::ROUNDS; r++) begin
            rk = dec_mode ? sched_keys[sm4_pkg::ROUNDS - 1 - r] : sched_keys[r];
            t = sbox_word(x[1] ^ x[2] ^ x[3] ^ rk);
            t = x[0] ^ t ^ rot_left(t, 2) ^ rot_left(t, 10) ^ rot_left(t, 18)
                ^ rot_left(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = t;
        end
        res.res_high = {x[3], x[2]};
        res.res_low  = {x[1], x[0]};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cipher_out want;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            dec_mode = 1'b0;
            for (int i = 0; i < sm4_pkg::ROUNDS; i++) sched_keys[i] = '0;
            cipher_results_q.delete();
            failures = 0;
        end else begin
            // register writes; any other address is ignored
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    KEY_HIGH_ADDR: begin
                        key_hi = i_pwdata;
                        load_round_keys();
                    end
                    KEY_LOW_ADDR: begin
                        key_lo = i_pwdata;
                        load_round_keys();
                    end
                    DECRYPT_ADDR: dec_mode = i_pwdata[0];
                    default: ;
                endcase
            end

            // predict on every input transfer
            if (i_in_valid && i_in_ready)
                cipher_results_q.push_back(sm4_crypt_block(i_in_data[63:0], i_in_data[127:64]));

            // compare each output transfer with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (cipher_results_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, got %h %h",
                             $time, i_out_data[63:0], i_out_data[127:64]);
                end else begin
                    want = cipher_results_q.pop_front();
                    if (i_out_data[63:0] !== want.res_high) begin
                        failures++;
                        $display("%0t: result_high mismatch, expected %h, got %h",
                                 $time, want.res_high, i_out_data[63:0]);
                    end
                    if (i_out_data[127:64] !== want.res_low) begin
                        failures++;
                        $display("%0t: result_low mismatch, expected %h, got %h",
                                 $time, want.res_low, i_out_data[127:64]);
                    end
                end
            end
        end
        o_fail_count <= failures;
        o_pending    <= cipher_results_q.size();
    end

endmodule

### bench/sm4_block_cipher_tb.sv
`timescale 1ns / 100ps

module sm4_block_cipher_tb;

    localparam logic [4:0] REG_KEY_HIGH = 5'd0;
    localparam logic [4:0] REG_KEY_LOW  = 5'd8;
    localparam logic [4:0] REG_DECRYPT  = 5'd16;
    localparam logic [4:0] REG_UNUSED   = 5'd24;

    localparam int RAND_PHASES     = 14;
    localparam int BLOCKS_PER_PHASE = 100;
    localparam int IDLE_PCT        = 21;
    localparam int STALL_LIMIT     = 2000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;    // [63:0] block_high, [127:64] block_low
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // [63:0] result_high, [127:64] result_low

    // no random idling on either side while set
    logic         steady = 1'b0;
    int           fail_count;
    int           results_pending;
    int           stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    sm4_block_cipher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sm4_stream_checker #(
        .KEY_HIGH_ADDR (REG_KEY_HIGH),
        .KEY_LOW_ADDR  (REG_KEY_LOW),
        .DECRYPT_ADDR  (REG_DECRYPT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    // output backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: cycles without any transfer on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // setup then access; psel stays up so writes can follow back to back
    task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one block transfer, optional idle cycles in front
    task automatic send_block(input logic [63:0] blk_hi, input logic [63:0] blk_lo);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk_lo, blk_hi};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    function automatic logic [63:0] rand_half();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int key_pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // standard vector key, encrypt, field extremes and bit patterns
        reg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
        reg_write(REG_KEY_LOW, 64'hfedcba9876543210);
        reg_write(REG_DECRYPT, 64'h0);
        bus_release();
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        send_block(64'h0000000000000001, 64'h8000000000000000);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain_results();

        // decrypt the known ciphertext back
        reg_write(REG_DECRYPT, 64'h1);
        bus_release();
        send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain_results();

        // all-zero key, encrypt
        reg_write(REG_KEY_HIGH, 64'h0);
        reg_write(REG_KEY_LOW, 64'h0);
        reg_write(REG_DECRYPT, 64'h0);
        bus_release();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain_results();

        // all-ones key, decrypt; only bit 0 of the mode word counts
        reg_write(REG_KEY_HIGH, '1);
        reg_write(REG_KEY_LOW, '1);
        reg_write(REG_DECRYPT, '1);
        bus_release();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain_results();

        // partial key update: new high half with the old low half
        reg_write(REG_KEY_HIGH, 64'h0123456789abcdef);
        bus_release();
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        send_block(64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00);
        drain_results();

        // write outside the register map must change nothing
        reg_write(REG_UNUSED, {$urandom, $urandom});
        bus_release();
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain_results();

        // random phases, each of which may pick a new key and direction
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            steady <= (ph == 6 || ph == 7);
            key_pick = $urandom_range(5);
            if (key_pick <= 2 || key_pick == 4)
                reg_write(REG_KEY_HIGH, rand_half());
            if (key_pick <= 1 || key_pick == 3 || key_pick == 4)
                reg_write(REG_KEY_LOW, rand_half());
            if ($urandom_range(9) < 7)
                reg_write(REG_DECRYPT, {$urandom, $urandom});
            if ($urandom_range(9) == 0)
                reg_write(REG_UNUSED, {$urandom, $urandom});
            bus_release();
            for (int n = 0; n < BLOCKS_PER_PHASE; n++)
                send_block(rand_half(), rand_half());
            drain_results();
        end

        // let any stray result show up
        repeat (sm4_pkg::ROUNDS + 8) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sm4_block_cipher.f
rtl/sm4_pkg.sv
rtl/sm4_key_exp.sv
rtl/sm4_round.sv
rtl/sm4_block_cipher.sv
bench/sm4_stream_checker.sv
bench/sm4_block_cipher_tb.sv
